[src/ssg_pkg.sv]
// Shared types and constants for the smoothed stereo gain block.
// No dependencies; every other file but ssg_checker uses this package.
package ssg_pkg;

    localparam int TARGET_W = 17;
    localparam int IDX_W    = 2;
    localparam int MODE_W   = 2;

    typedef logic [TARGET_W-1:0] t_target;
    typedef logic [IDX_W-1:0]    t_cfg_idx;
    typedef logic [MODE_W-1:0]   t_mode;

    localparam t_target TARGET_UNITY = 17'd65536;

    localparam t_cfg_idx CFG_LEFT_TARGET  = 2'd0;
    localparam t_cfg_idx CFG_RIGHT_TARGET = 2'd1;
    localparam t_cfg_idx CFG_CHANNEL_MODE = 2'd2;

    localparam t_mode MODE_MONO   = 2'd0;
    localparam t_mode MODE_STEREO = 2'd1;
    localparam t_mode MODE_DUP    = 2'd2;

    typedef struct packed {
        logic load;
        logic mono;
    } t_merge_ctl;

endpackage

[src/ssg_if.sv]
// Handshake interfaces for the frame input, frame output and register write channels.
// Depends on ssg_pkg for the register index and data widths.
interface ssg_in_if #(parameter int SAMPLE_WIDTH = 16);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] in_left;
    logic signed [SAMPLE_WIDTH-1:0] in_right;
    logic                           block_end;

    modport source (output valid, output in_left, output in_right, output block_end,
                    input ready);
    modport sink   (input valid, input in_left, input in_right, input block_end,
                    output ready);
endinterface

interface ssg_out_if #(parameter int SAMPLE_WIDTH = 16);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] out_left;
    logic signed [SAMPLE_WIDTH-1:0] out_right;
    logic                           block_end_out;

    modport source (output valid, output out_left, output out_right, output block_end_out,
                    input ready);
    modport sink   (input valid, input out_left, input out_right, input block_end_out,
                    output ready);
endinterface

interface ssg_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [ssg_pkg::IDX_W-1:0]    index;
    logic [ssg_pkg::TARGET_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/ssg_lane.sv]
// One gain lane: running gain with one-pole smoothing, sample multiplier and saturation.
// Depends on ssg_pkg for the target type.
module ssg_lane #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_step,
    input  logic                                i_mul,
    input  ssg_pkg::t_target                    i_target,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample,
    input  logic [GAIN_FRAC_BITS+1:0]           i_op_gain,
    input  logic                                i_half,
    output logic [GAIN_FRAC_BITS:0]             o_gain,
    output logic signed [SAMPLE_WIDTH-1:0]      o_result
);
    import ssg_pkg::*;

    localparam int          GW   = GAIN_FRAC_BITS + 1;
    localparam longint      COEF = ((64'd25 << GAIN_FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam int          CW   = $clog2(COEF + 1);
    localparam int          DW   = GW + CW;
    localparam int          PW   = SAMPLE_WIDTH + GW + 1;
    localparam int          QW   = PW - GAIN_FRAC_BITS;
    localparam logic [CW-1:0] COEF_C = CW'(COEF);
    localparam logic [QW-1:0] MAX_POS = {{(QW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [QW-1:0] MAX_NEG = QW'(1) << (SAMPLE_WIDTH - 1);

    logic [GW-1:0]           r_gain;
    logic                    r_up;
    logic [DW-1:0]           r_dprod;
    logic                    r_neg;
    logic [SAMPLE_WIDTH-1:0] r_mag;
    logic [PW-1:0]           r_sprod;
    logic                    r_half;

    logic [GW-1:0]           w_target;
    logic [GW-1:0]           w_diff;
    logic [GW-1:0]           w_floor;
    logic [GW-1:0]           n_gain;
    logic [QW-1:0]           w_q;
    logic [QW-1:0]           w_sat;

    assign w_target = GW'(i_target) << (GAIN_FRAC_BITS - 16);
    assign w_diff   = (w_target >= r_gain) ? (w_target - r_gain) : (r_gain - w_target);
    assign w_floor  = GW'(r_dprod >> GAIN_FRAC_BITS);
    assign n_gain   = r_up ? (r_gain + w_floor)
                           : (r_gain - w_floor - GW'(|r_dprod[GAIN_FRAC_BITS-1:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GW'(1) << GAIN_FRAC_BITS;
        end else if (i_step) begin
            r_gain <= n_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_up    <= (w_target >= r_gain);
            r_dprod <= DW'(w_diff) * DW'(COEF_C);
            r_neg   <= i_sample[SAMPLE_WIDTH-1];
            r_mag   <= i_sample[SAMPLE_WIDTH-1] ? (SAMPLE_WIDTH'(0) - SAMPLE_WIDTH'(i_sample))
                                                : SAMPLE_WIDTH'(i_sample);
        end
        if (i_mul) begin
            r_sprod <= PW'(r_mag) * PW'(i_op_gain);
            r_half  <= i_half;
        end
    end

    assign w_q = r_half ? QW'(r_sprod >> (GAIN_FRAC_BITS + 1)) : r_sprod[PW-1:GAIN_FRAC_BITS];

    always_comb begin
        if (r_neg) begin
            w_sat = (w_q > MAX_NEG) ? MAX_NEG : w_q;
        end else begin
            w_sat = (w_q > MAX_POS) ? MAX_POS : w_q;
        end
    end

    assign o_result = r_neg ? (SAMPLE_WIDTH'(0) - w_sat[SAMPLE_WIDTH-1:0])
                            : w_sat[SAMPLE_WIDTH-1:0];
    assign o_gain   = r_gain;

endmodule

[src/ssg_merge.sv]
// Merge stage: picks the lane results for the channel mode and holds the output item.
// Depends on ssg_pkg for the control struct and on ssg_out_if.
module ssg_merge #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ssg_pkg::t_merge_ctl            i_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_left,
    input  logic signed [SAMPLE_WIDTH-1:0] i_right,
    input  logic signed [SAMPLE_WIDTH-1:0] i_right_pass,
    input  logic                           i_end,
    output logic                           o_can_load,
    ssg_out_if.source                      o_out
);
    import ssg_pkg::*;

    logic                           r_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_left;
    logic signed [SAMPLE_WIDTH-1:0] r_right;
    logic                           r_end;

    assign o_can_load = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load && o_can_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && o_can_load) begin
            r_left  <= i_left;
            r_right <= i_ctl.mono ? i_right_pass : i_right;
            r_end   <= i_end;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.out_left      = r_left;
    assign o_out.out_right     = r_right;
    assign o_out.block_end_out = r_end;

endmodule

[src/smoothed_stereo_gain.sv]
// Smoothed stereo gain stage: top level with registers, sequencer, two lanes and merge.
// Depends on ssg_pkg, ssg_if, ssg_lane and ssg_merge.
//
// Usage:
//   i_in takes one frame per item (in_left, in_right, block_end); o_out returns one
//   frame per item (out_left, out_right, block_end_out). i_cfg writes left_target (0),
//   right_target (1) and channel_mode (2); it is always ready, index 3 is ignored and
//   targets above unity saturate. Write registers only while no frame is in flight.
//   Each frame goes in order from acceptance to the output register: gain difference
//   product on the accepting cycle, gain update, sample multiply, then saturate and load.
//   Both channels run in their own lane, so the sequencer sets the rate: a frame is taken
//   only after the last is loaded, i_in.ready high only while the sequencer waits for one.
//   The output register parts the two sides: the next frame is accepted while a result
//   waits; if the receiver stalls, the following frame waits in its last step.
//   Synchronous reset restores unity gains and targets, stereo mode and empty output.
module smoothed_stereo_gain #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssg_in_if.sink     i_in,
    ssg_cfg_if.sink    i_cfg,
    ssg_out_if.source  o_out
);
    import ssg_pkg::*;

    localparam int GW = GAIN_FRAC_BITS + 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_STEP = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state                         r_state;
    t_state                         n_state;
    t_target                        r_left_target;
    t_target                        r_right_target;
    t_mode                          r_mode;
    logic signed [SAMPLE_WIDTH-1:0] r_right;
    logic                           r_end;

    logic                           w_accept;
    logic                           w_mono;
    logic                           w_can_load;
    t_target                        w_cfg_sat;
    logic signed [SAMPLE_WIDTH-1:0] w_right_sample;
    logic [GW-1:0]                  w_gain_l;
    logic [GW-1:0]                  w_gain_r;
    logic [GW:0]                    w_op_l;
    logic signed [SAMPLE_WIDTH-1:0] w_res_l;
    logic signed [SAMPLE_WIDTH-1:0] w_res_r;
    t_merge_ctl                     w_ctl;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_mono      = (r_mode == MODE_MONO);
    assign w_cfg_sat   = (i_cfg.data > TARGET_UNITY) ? TARGET_UNITY : i_cfg.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_target  <= TARGET_UNITY;
            r_right_target <= TARGET_UNITY;
            r_mode         <= MODE_STEREO;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_LEFT_TARGET:  r_left_target  <= w_cfg_sat;
                CFG_RIGHT_TARGET: r_right_target <= w_cfg_sat;
                CFG_CHANNEL_MODE: r_mode         <= i_cfg.data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (r_state)
            ST_IDLE: n_state = w_accept ? ST_STEP : ST_IDLE;
            ST_STEP: n_state = ST_MUL;
            ST_MUL:  n_state = ST_OUT;
            ST_OUT:  n_state = w_can_load ? ST_IDLE : ST_OUT;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_right <= i_in.in_right;
            r_end   <= i_in.block_end;
        end
    end

    assign w_right_sample = (r_mode == MODE_DUP) ? i_in.in_left : i_in.in_right;
    assign w_op_l = w_mono ? ({1'b0, w_gain_l} + {1'b0, w_gain_r}) : {1'b0, w_gain_l};

    ssg_lane #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_lane_l (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_step    (r_state == ST_STEP),
        .i_mul     (r_state == ST_MUL),
        .i_target  (r_left_target),
        .i_sample  (i_in.in_left),
        .i_op_gain (w_op_l),
        .i_half    (w_mono),
        .o_gain    (w_gain_l),
        .o_result  (w_res_l)
    );

    ssg_lane #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_lane_r (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_step    (r_state == ST_STEP),
        .i_mul     (r_state == ST_MUL),
        .i_target  (r_right_target),
        .i_sample  (w_right_sample),
        .i_op_gain ({1'b0, w_gain_r}),
        .i_half    (1'b0),
        .o_gain    (w_gain_r),
        .o_result  (w_res_r)
    );

    assign w_ctl.load = (r_state == ST_OUT);
    assign w_ctl.mono = w_mono;

    ssg_merge #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_left       (w_res_l),
        .i_right      (w_res_r),
        .i_right_pass (r_right),
        .i_end        (r_end),
        .o_can_load   (w_can_load),
        .o_out        (o_out)
    );

endmodule

[src/ssg_checker.sv]
// Port-level checks for the smoothed stereo gain block, bound to the top level.
// Depends only on the top level's port signals.
module ssg_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [SAMPLE_WIDTH-1:0] i_out_left,
    input logic [SAMPLE_WIDTH-1:0] i_out_right,
    input logic                    i_out_end
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_left) && $stable(i_out_right) && $stable(i_out_end))
        else $error("output item changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item accepted while one is in flight");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> !i_out_valid)
        else $error("result appeared one cycle after acceptance");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind smoothed_stereo_gain ssg_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_ssg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_left  (o_out.out_left),
    .i_out_right (o_out.out_right),
    .i_out_end   (o_out.block_end_out)
);
